>>> design/bbc_pkg.sv
// Shared types and constants for the clamped-border box blur.
// No dependencies.
`default_nettype none

package bbc_pkg;

   localparam int ROW_W = 13;  // holds image heights up to 4096
   localparam int COL_W = 11;  // width register width
   localparam int LIN_W = 23;  // raster index within one image
   localparam int PIX_W = 24;  // packed pixel: blue, green, red

   localparam logic [1:0] CFG_WIDTH  = 2'd0;
   localparam logic [1:0] CFG_HEIGHT = 2'd1;
   localparam logic [1:0] CFG_RADIUS = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic clear;  // zero the sum before a window scan
      logic add;    // accumulate the byte read from the store
      logic step;   // one restoring division step
   } lane_ctl_type;

endpackage

`default_nettype wire

>>> design/bbc_store.sv
// Pixel ring store: one write port, one registered read port.
// Depends on bbc_pkg.
`default_nettype none

module bbc_store #(
   parameter int DEPTH = 15360,
   parameter int AW    = 14
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [bbc_pkg::PIX_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [bbc_pkg::PIX_W-1:0] rd_data_ff
);

   logic [bbc_pkg::PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/bbc_lane.sv
// One channel lane: window sum accumulator and bit-serial restoring divider.
// Depends on bbc_pkg.
`default_nettype none

module bbc_lane #(
   parameter int SUM_W  = 16,
   parameter int AREA_W = 8
) (
   input  wire logic                 clock,
   input  wire bbc_pkg::lane_ctl_type ctl,
   input  wire logic [7:0]           add_val,
   input  wire logic [AREA_W-1:0]    divisor,
   output logic      [7:0]           quotient
);

   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [AREA_W-1:0] rem_ff;
   logic [AREA_W-1:0] rem_in;
   logic [AREA_W:0]   trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, sum_ff[SUM_W-1]};
      fits   = trial >= {1'b0, divisor};
      sum_in = sum_ff;
      rem_in = rem_ff;
      if (ctl.clear) begin
         sum_in = '0;
         rem_in = '0;
      end else if (ctl.add) begin
         sum_in = sum_ff + SUM_W'(add_val);
      end else if (ctl.step) begin
         // sum register shifts out dividend bits and takes quotient bits
         sum_in = {sum_ff[SUM_W-2:0], fits};
         rem_in = fits ? AREA_W'(trial - {1'b0, divisor}) : AREA_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      rem_ff <= rem_in;
   end

   assign quotient = sum_ff[7:0];

endmodule

`default_nettype wire

>>> design/box_blur_clamped_border_core.sv
// Top level of the clamped-border box blur: sequencer, store, three lanes
// and the merging output register. Depends on bbc_pkg, bbc_store, bbc_lane.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    cmd, blue_in, green_in, red_in
//   rsp      out        rsp_valid/stall    blue/green/red_out, row, col, last
//   csr      in         csr_valid/ready    index, data
//
// A request passes CHECK and CMP and goes back to IDLE when no pixel is due;
// otherwise the window is read one pixel per cycle from the single store
// read port in SCAN; after DRAIN the three lanes divide bit-serially in
// parallel in DIV; OUT waits out any output stall. Reset is synchronous; the
// store holds garbage until written. A stalled result is held while the next
// request is taken; csr writes are taken only while idle with no request.
`default_nettype none

module box_blur_clamped_border_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_red_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_red_out,
   output logic [11:0]      rsp_out_row,
   output logic [9:0]       rsp_out_col,
   output logic             rsp_last_pixel,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);

   localparam int ROW_W  = bbc_pkg::ROW_W;
   localparam int COL_W  = bbc_pkg::COL_W;
   localparam int LIN_W  = bbc_pkg::LIN_W;
   localparam int KMAX   = 2 * MAX_RADIUS + 1;
   localparam int DEPTH  = MAX_WIDTH * KMAX;
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = $clog2(MAX_RADIUS + 1);
   localparam int KW     = $clog2(KMAX + 1);
   localparam int AREA_W = $clog2(KMAX * KMAX + 1);
   localparam int SUM_W  = $clog2(KMAX * KMAX * 255 + 1);
   localparam int OFF_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int DCW    = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      IDLE, CHECK, CMP, SCAN, DRAIN, DIV, OUT
   } state_type;

   state_type state_ff;

   logic [COL_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [2:0]       radius_ff;

   logic [ROW_W-1:0] in_row_ff, emit_row_ff;
   logic [COL_W-1:0] in_col_ff, emit_col_ff;
   logic [LIN_W-1:0] in_lin_ff;
   logic [AW-1:0]    in_slot_ff, emit_slot_ff;

   logic [ROW_W-1:0]  rhi_ff, rlo_ff, row_ff;
   logic [COL_W-1:0]  chi_ff, clo_ff, col_ff;
   logic [LIN_W-1:0]  prod_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [AREA_W-1:0] area_ff;
   logic              interior_ff, last_ff;
   logic [AW-1:0]     addr_ff, row_base_ff;
   logic              rd_valid_ff;
   logic [DCW-1:0]    div_cnt_ff;

   logic [7:0]  out_b_ff, out_g_ff, out_r_ff;
   logic [11:0] out_row_ff;
   logic [9:0]  out_col_ff;
   logic        out_last_ff, rsp_valid_ff;

   // effective configuration
   logic [COL_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [RW-1:0]    r_eff;

   always_comb begin
      if (width_ff == '0) w_eff = COL_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = COL_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = ROW_W'(1);
      else if (height_ff > ROW_W'(4096)) h_eff = ROW_W'(4096);
      else h_eff = height_ff;
      if (radius_ff == '0) r_eff = RW'(1);
      else if (32'(radius_ff) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
      else r_eff = RW'(radius_ff);
   end

   // window bounds for the next output position
   logic [ROW_W:0]   er_pr;
   logic [COL_W:0]   ec_pr;
   logic [ROW_W-1:0] rhi_in, rlo_in, r_row;
   logic [COL_W-1:0] chi_in, clo_in, r_col;
   logic [RW-1:0]    rr_in, cc_in;
   logic [KW-1:0]    nrows, ncols, kside;
   logic             interior_in, last_in;
   logic [AREA_W-1:0] area_in;
   logic [LIN_W-1:0] prod_in;
   logic [OFF_W-1:0] off_in;

   always_comb begin
      r_row  = ROW_W'(r_eff);
      r_col  = COL_W'(r_eff);
      er_pr  = {1'b0, emit_row_ff} + {1'b0, r_row};
      ec_pr  = {1'b0, emit_col_ff} + {1'b0, r_col};
      rhi_in = (er_pr > {1'b0, h_eff - 1'b1}) ? h_eff - 1'b1 : er_pr[ROW_W-1:0];
      chi_in = (ec_pr > {1'b0, w_eff - 1'b1}) ? w_eff - 1'b1 : ec_pr[COL_W-1:0];
      rlo_in = (emit_row_ff >= r_row) ? emit_row_ff - r_row : '0;
      clo_in = (emit_col_ff >= r_col) ? emit_col_ff - r_col : '0;
      rr_in  = RW'(emit_row_ff - rlo_in);
      cc_in  = RW'(emit_col_ff - clo_in);
      interior_in = (emit_row_ff >= r_row) && (emit_col_ff >= r_col) &&
                    (er_pr < {1'b0, h_eff}) && (ec_pr < {1'b0, w_eff});
      last_in = (emit_row_ff == h_eff - 1'b1) && (emit_col_ff == w_eff - 1'b1);
      nrows  = KW'(rhi_in - rlo_in) + KW'(1);
      ncols  = KW'(chi_in - clo_in) + KW'(1);
      kside  = KW'({r_eff, 1'b0}) + KW'(1);
      if (interior_in) area_in = AREA_W'(kside * kside) - AREA_W'(1);
      else area_in = AREA_W'(nrows * ncols);
      prod_in = LIN_W'(rhi_in * w_eff);
      off_in  = OFF_W'(rr_in * w_eff) + OFF_W'(cc_in);
   end

   // address arithmetic modulo the store depth
   logic [AW:0]   start_diff, base_sum, addr_sum;
   logic [AW-1:0] start_addr, next_base, next_addr, emit_slot_nx, in_slot_nx;
   logic          skip_px, rd_en, ready_now;

   always_comb begin
      start_diff = {1'b0, emit_slot_ff} - (AW+1)'(off_ff);
      start_addr = start_diff[AW] ? AW'(start_diff + (AW+1)'(DEPTH))
                                  : start_diff[AW-1:0];
      base_sum   = {1'b0, row_base_ff} + (AW+1)'(w_eff);
      next_base  = (base_sum >= (AW+1)'(DEPTH)) ? AW'(base_sum - (AW+1)'(DEPTH))
                                                 : base_sum[AW-1:0];
      addr_sum   = {1'b0, addr_ff} + (AW+1)'(1);
      next_addr  = (addr_sum == (AW+1)'(DEPTH)) ? '0 : addr_sum[AW-1:0];
      emit_slot_nx = ({1'b0, emit_slot_ff} + (AW+1)'(1) == (AW+1)'(DEPTH)) ? '0
                     : emit_slot_ff + 1'b1;
      in_slot_nx   = ({1'b0, in_slot_ff} + (AW+1)'(1) == (AW+1)'(DEPTH)) ? '0
                     : in_slot_ff + 1'b1;
      skip_px   = interior_ff && (row_ff == emit_row_ff) && (col_ff == emit_col_ff);
      rd_en     = (state_ff == SCAN) && !skip_px;
      ready_now = (in_row_ff >= h_eff) ||
                  ((prod_ff + LIN_W'(chi_ff)) < in_lin_ff);
   end

   logic req_take, store_px, out_free;

   assign req_take = req_valid && !req_stall;
   assign store_px = req_take && (req_cmd == bbc_pkg::CMD_PIXEL) && (in_row_ff < h_eff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   logic [bbc_pkg::PIX_W-1:0] rd_data;

   bbc_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock      (clock),
      .wr_en      (store_px),
      .wr_addr    (in_slot_ff),
      .wr_data    ({req_red_in, req_green_in, req_blue_in}),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .rd_data_ff (rd_data)
   );

   bbc_pkg::lane_ctl_type lane_ctl;
   logic [7:0] quo [3];

   assign lane_ctl.clear = (state_ff == CMP);
   assign lane_ctl.add   = rd_valid_ff;
   assign lane_ctl.step  = (state_ff == DIV);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      bbc_lane #(.SUM_W(SUM_W), .AREA_W(AREA_W)) u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .add_val  (rd_data[8*i +: 8]),
         .divisor  (area_ff),
         .quotient (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         width_ff     <= COL_W'(640);
         height_ff    <= ROW_W'(480);
         radius_ff    <= 3'd1;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_lin_ff    <= '0;
         in_slot_ff   <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         emit_slot_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         rd_valid_ff <= rd_en;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready && (csr_index inside
             {bbc_pkg::CFG_WIDTH, bbc_pkg::CFG_HEIGHT, bbc_pkg::CFG_RADIUS})) begin
            case (csr_index)
               bbc_pkg::CFG_WIDTH:  width_ff  <= csr_data[COL_W-1:0];
               bbc_pkg::CFG_HEIGHT: height_ff <= csr_data;
               bbc_pkg::CFG_RADIUS: radius_ff <= csr_data[2:0];
               default:             width_ff  <= width_ff;
            endcase
            in_row_ff    <= '0;
            in_col_ff    <= '0;
            in_lin_ff    <= '0;
            in_slot_ff   <= '0;
            emit_row_ff  <= '0;
            emit_col_ff  <= '0;
            emit_slot_ff <= '0;
         end
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  if (store_px) begin
                     in_lin_ff  <= in_lin_ff + 1'b1;
                     in_slot_ff <= in_slot_nx;
                     if (in_col_ff + 1'b1 >= w_eff) begin
                        in_col_ff <= '0;
                        in_row_ff <= in_row_ff + 1'b1;
                     end else begin
                        in_col_ff <= in_col_ff + 1'b1;
                     end
                  end
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               rhi_ff      <= rhi_in;
               rlo_ff      <= rlo_in;
               chi_ff      <= chi_in;
               clo_ff      <= clo_in;
               interior_ff <= interior_in;
               last_ff     <= last_in;
               area_ff     <= area_in;
               prod_ff     <= prod_in;
               off_ff      <= off_in;
               state_ff    <= CMP;
            end
            CMP: begin
               row_ff      <= rlo_ff;
               col_ff      <= clo_ff;
               addr_ff     <= start_addr;
               row_base_ff <= start_addr;
               state_ff    <= ready_now ? SCAN : IDLE;
            end
            SCAN: begin
               if (col_ff == chi_ff) begin
                  col_ff      <= clo_ff;
                  row_ff      <= row_ff + 1'b1;
                  row_base_ff <= next_base;
                  addr_ff     <= next_base;
                  if (row_ff == rhi_ff) begin
                     state_ff <= DRAIN;
                  end
               end else begin
                  col_ff  <= col_ff + 1'b1;
                  addr_ff <= next_addr;
               end
            end
            DRAIN: begin
               div_cnt_ff <= '0;
               state_ff   <= DIV;
            end
            DIV: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DCW'(SUM_W - 1)) begin
                  state_ff <= OUT;
               end
            end
            OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_b_ff     <= quo[0];
                  out_g_ff     <= quo[1];
                  out_r_ff     <= quo[2];
                  out_row_ff   <= emit_row_ff[11:0];
                  out_col_ff   <= emit_col_ff[9:0];
                  out_last_ff  <= last_ff;
                  if (last_ff) begin
                     in_row_ff    <= '0;
                     in_col_ff    <= '0;
                     in_lin_ff    <= '0;
                     in_slot_ff   <= '0;
                     emit_row_ff  <= '0;
                     emit_col_ff  <= '0;
                     emit_slot_ff <= '0;
                  end else begin
                     emit_slot_ff <= emit_slot_nx;
                     if (emit_col_ff + 1'b1 >= w_eff) begin
                        emit_col_ff <= '0;
                        emit_row_ff <= emit_row_ff + 1'b1;
                     end else begin
                        emit_col_ff <= emit_col_ff + 1'b1;
                     end
                  end
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != IDLE);
   // keep csr writes away from a request in flight or being offered
   assign csr_ready      = (state_ff == IDLE) && !req_valid;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_out   = out_b_ff;
   assign rsp_green_out  = out_g_ff;
   assign rsp_red_out    = out_r_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_last_pixel = out_last_ff;

endmodule

`default_nettype wire

>>> design/bbc_checker.sv
// Port-level checks for the box blur core, bound to the top level.
// Depends on box_blur_clamped_border_core.
`default_nettype none

module bbc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_blue_out,
   input wire logic [11:0] rsp_out_row,
   input wire logic [9:0]  rsp_out_col
);

   // a taken request always leaves the block busy in the cycle after it
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core free right after taking a request");

   // a new result only comes out of a busy sequencer
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blue_out) &&
         $stable(rsp_out_row) && $stable(rsp_out_col))
      else $error("stalled result changed");

endmodule

bind box_blur_clamped_border_core bbc_checker u_bbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_blue_out (rsp_blue_out),
   .rsp_out_row  (rsp_out_row),
   .rsp_out_col  (rsp_out_col)
);

`default_nettype wire
